/* hdl/segi_pkg.sv */
// package for the segment intersection core: shared width defaults
// no dependencies; compiled before every other file

package segi_pkg;

   localparam int COORD_WIDTH_DEFAULT = 12;

endpackage

/* hdl/segi_if.sv */
// request and response channel interfaces of the segment intersection core
// depends on segi_pkg for the default coordinate width

interface segi_req_if
   import segi_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] ax_start;
   logic signed [COORD_WIDTH-1:0] ay_start;
   logic signed [COORD_WIDTH-1:0] ax_end;
   logic signed [COORD_WIDTH-1:0] ay_end;
   logic signed [COORD_WIDTH-1:0] bx_start;
   logic signed [COORD_WIDTH-1:0] by_start;
   logic signed [COORD_WIDTH-1:0] bx_end;
   logic signed [COORD_WIDTH-1:0] by_end;

   modport source (
      output valid, ax_start, ay_start, ax_end, ay_end,
             bx_start, by_start, bx_end, by_end,
      input  ready
   );
   modport sink (
      input  valid, ax_start, ay_start, ax_end, ay_end,
             bx_start, by_start, bx_end, by_end,
      output ready
   );
endinterface

interface segi_rsp_if
   import segi_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic signed [COORD_WIDTH-1:0] cross_x;
   logic signed [COORD_WIDTH-1:0] cross_y;

   modport source (
      output valid, hit, cross_x, cross_y,
      input  ready
   );
   modport sink (
      input  valid, hit, cross_x, cross_y,
      output ready
   );
endinterface

/* hdl/segment_intersection_core.sv */
// top level of the segment intersection core: front pipeline and output register
// depends on segi_pkg, segi_if (channels) and segi_div
//
// usage
//   req_chan carries two segments, A from (ax_start,ay_start) to (ax_end,ay_end)
//   and B from (bx_start,by_start) to (bx_end,by_end), as one item per handshake.
//   rsp_chan returns one item per request, in order: hit, and the crossing point
//   rounded onto A in cross_x/cross_y (both zero on a miss or parallel segments).
//   a request is taken on an edge with valid and ready high; a new item can
//   enter every cycle, so throughput is one item per clock while rsp is taken.
//   on its way to the response, the item is loaded into the first of nine
//   arithmetic stages at the accepting edge, then passes COORD_WIDTH + 1
//   divider stages and one output register.
//   all stages advance together; while rsp_chan holds back ready with a result
//   pending, the whole pipeline holds and req_chan.ready drops, nothing lost.
//   synchronous reset empties the pipeline; no result is offered after it.

module segment_intersection_core
   import segi_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   segi_req_if.sink  req_chan,
   segi_rsp_if.source rsp_chan
);

   localparam int W      = COORD_WIDTH;
   localparam int DW     = W + 1;
   localparam int PW     = 2 * W + 2;
   localparam int NW     = 2 * W + 3;
   localparam int MW     = 2 * W + 2;
   localparam int HW     = W + 1;
   localparam int PPW    = 3 * W + 3;
   localparam int TW     = 3 * W + 5;
   localparam int REM_W  = 3 * W + 3;
   localparam int DIV_W  = 2 * W + 3;
   localparam int QUO_W  = W + 1;
   localparam int SIDE_W = 2 * W + 3;

   logic ce;
   logic out_v_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;

   assign ce             = ~out_v_ff | rsp_chan.ready;
   assign req_chan.ready = ce;

   // stage 1: differences
   logic signed [W-1:0]  x1_1_ff, y1_1_ff;
   logic signed [DW-1:0] dxa_ff, dya_ff, dxb_ff, dyb_ff, ox_ff, oy_ff;
   // stage 2: products
   logic signed [W-1:0]  x1_2_ff, y1_2_ff;
   logic signed [DW-1:0] dxa_2_ff, dya_2_ff;
   logic signed [PW-1:0] p_da_ff, p_db_ff, p_aa_ff, p_ab_ff, p_ba_ff, p_bb_ff;
   // stage 3: denominator and numerators
   logic signed [W-1:0]  x1_3_ff, y1_3_ff;
   logic signed [DW-1:0] dxa_3_ff, dya_3_ff;
   logic signed [NW-1:0] den_3_ff, na_3_ff, nb_3_ff;
   // stage 4: sign normalized
   logic signed [W-1:0]  x1_4_ff, y1_4_ff;
   logic signed [DW-1:0] dxa_4_ff, dya_4_ff;
   logic signed [NW-1:0] den_4_ff, na_4_ff, nb_4_ff;
   logic                 dz_4_ff;
   // stage 5: hit test and magnitudes
   logic signed [W-1:0]  x1_5_ff, y1_5_ff;
   logic                 hit_5_ff, negx_5_ff, negy_5_ff;
   logic [HW-1:0]        magx_5_ff, magy_5_ff;
   logic [MW-1:0]        den_5_ff, na_5_ff;
   // stage 6: partial products
   logic signed [W-1:0]  x1_6_ff, y1_6_ff;
   logic                 hit_6_ff, negx_6_ff, negy_6_ff;
   logic [MW-1:0]        den_6_ff;
   logic [PW-1:0]        plx_6_ff, phx_6_ff, ply_6_ff, phy_6_ff;
   // stage 7: full products
   logic signed [W-1:0]  x1_7_ff, y1_7_ff;
   logic                 hit_7_ff, negx_7_ff, negy_7_ff;
   logic [MW-1:0]        den_7_ff;
   logic [PPW-1:0]       px_7_ff, py_7_ff;
   // stage 8: rounding numerators
   logic signed [W-1:0]  x1_8_ff, y1_8_ff;
   logic                 hit_8_ff;
   logic [MW-1:0]        den_8_ff;
   logic [TW-1:0]        tx_8_ff, ty_8_ff;
   // stage 9: magnitudes into the divider
   logic [SIDE_W-1:0]    side_9_ff;
   logic [REM_W-1:0]     remx_9_ff, remy_9_ff;
   logic [DIV_W-1:0]     div_9_ff;

   logic signed [DW-1:0] dxa_in, dya_in, dxb_in, dyb_in, ox_in, oy_in;
   logic signed [NW-1:0] den_in, na_in, nb_in;
   logic                 hit_in;
   logic [HW-1:0]        nlo, nhi;
   logic [PPW-1:0]       px_in, py_in;
   logic [TW-1:0]        two_px, two_py, den_ext, tx_in, ty_in;
   logic [REM_W-1:0]     remx_in, remy_in;

   always_comb begin
      dxa_in = DW'(req_chan.ax_end) - DW'(req_chan.ax_start);
      dya_in = DW'(req_chan.ay_end) - DW'(req_chan.ay_start);
      dxb_in = DW'(req_chan.bx_end) - DW'(req_chan.bx_start);
      dyb_in = DW'(req_chan.by_end) - DW'(req_chan.by_start);
      ox_in  = DW'(req_chan.ax_start) - DW'(req_chan.bx_start);
      oy_in  = DW'(req_chan.ay_start) - DW'(req_chan.by_start);

      den_in = NW'(p_da_ff) - NW'(p_db_ff);
      na_in  = NW'(p_aa_ff) - NW'(p_ab_ff);
      nb_in  = NW'(p_ba_ff) - NW'(p_bb_ff);

      hit_in = ~dz_4_ff & ~na_4_ff[NW-1] & (na_4_ff <= den_4_ff)
               & ~nb_4_ff[NW-1] & (nb_4_ff <= den_4_ff);

      nlo = na_5_ff[HW-1:0];
      nhi = na_5_ff[MW-1:HW];

      px_in = PPW'(plx_6_ff) + (PPW'(phx_6_ff) << HW);
      py_in = PPW'(ply_6_ff) + (PPW'(phy_6_ff) << HW);

      two_px  = {1'b0, px_7_ff, 1'b0};
      two_py  = {1'b0, py_7_ff, 1'b0};
      den_ext = TW'(den_7_ff);
      tx_in   = negx_7_ff ? den_ext - two_px : den_ext + two_px;
      ty_in   = negy_7_ff ? den_ext - two_py : den_ext + two_py;

      remx_in = tx_8_ff[TW-1] ? REM_W'(-tx_8_ff) : REM_W'(tx_8_ff);
      remy_in = ty_8_ff[TW-1] ? REM_W'(-ty_8_ff) : REM_W'(ty_8_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         x1_1_ff <= req_chan.ax_start;
         y1_1_ff <= req_chan.ay_start;
         dxa_ff  <= dxa_in;
         dya_ff  <= dya_in;
         dxb_ff  <= dxb_in;
         dyb_ff  <= dyb_in;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;

         x1_2_ff  <= x1_1_ff;
         y1_2_ff  <= y1_1_ff;
         dxa_2_ff <= dxa_ff;
         dya_2_ff <= dya_ff;
         p_da_ff  <= PW'(dyb_ff) * PW'(dxa_ff);
         p_db_ff  <= PW'(dxb_ff) * PW'(dya_ff);
         p_aa_ff  <= PW'(dxb_ff) * PW'(oy_ff);
         p_ab_ff  <= PW'(dyb_ff) * PW'(ox_ff);
         p_ba_ff  <= PW'(dxa_ff) * PW'(oy_ff);
         p_bb_ff  <= PW'(dya_ff) * PW'(ox_ff);

         x1_3_ff  <= x1_2_ff;
         y1_3_ff  <= y1_2_ff;
         dxa_3_ff <= dxa_2_ff;
         dya_3_ff <= dya_2_ff;
         den_3_ff <= den_in;
         na_3_ff  <= na_in;
         nb_3_ff  <= nb_in;

         x1_4_ff  <= x1_3_ff;
         y1_4_ff  <= y1_3_ff;
         dxa_4_ff <= dxa_3_ff;
         dya_4_ff <= dya_3_ff;
         dz_4_ff  <= (den_3_ff == '0);
         den_4_ff <= den_3_ff[NW-1] ? -den_3_ff : den_3_ff;
         na_4_ff  <= den_3_ff[NW-1] ? -na_3_ff : na_3_ff;
         nb_4_ff  <= den_3_ff[NW-1] ? -nb_3_ff : nb_3_ff;

         x1_5_ff   <= x1_4_ff;
         y1_5_ff   <= y1_4_ff;
         hit_5_ff  <= hit_in;
         negx_5_ff <= dxa_4_ff[DW-1];
         negy_5_ff <= dya_4_ff[DW-1];
         magx_5_ff <= dxa_4_ff[DW-1] ? HW'(-dxa_4_ff) : HW'(dxa_4_ff);
         magy_5_ff <= dya_4_ff[DW-1] ? HW'(-dya_4_ff) : HW'(dya_4_ff);
         den_5_ff  <= den_4_ff[MW-1:0];
         na_5_ff   <= na_4_ff[MW-1:0];

         x1_6_ff   <= x1_5_ff;
         y1_6_ff   <= y1_5_ff;
         hit_6_ff  <= hit_5_ff;
         negx_6_ff <= negx_5_ff;
         negy_6_ff <= negy_5_ff;
         den_6_ff  <= den_5_ff;
         plx_6_ff  <= PW'(nlo) * PW'(magx_5_ff);
         phx_6_ff  <= PW'(nhi) * PW'(magx_5_ff);
         ply_6_ff  <= PW'(nlo) * PW'(magy_5_ff);
         phy_6_ff  <= PW'(nhi) * PW'(magy_5_ff);

         x1_7_ff   <= x1_6_ff;
         y1_7_ff   <= y1_6_ff;
         hit_7_ff  <= hit_6_ff;
         negx_7_ff <= negx_6_ff;
         negy_7_ff <= negy_6_ff;
         den_7_ff  <= den_6_ff;
         px_7_ff   <= px_in;
         py_7_ff   <= py_in;

         x1_8_ff  <= x1_7_ff;
         y1_8_ff  <= y1_7_ff;
         hit_8_ff <= hit_7_ff;
         den_8_ff <= den_7_ff;
         tx_8_ff  <= tx_in;
         ty_8_ff  <= ty_in;

         side_9_ff <= {hit_8_ff, tx_8_ff[TW-1], ty_8_ff[TW-1], x1_8_ff, y1_8_ff};
         remx_9_ff <= remx_in;
         remy_9_ff <= remy_in;
         div_9_ff  <= {den_8_ff, 1'b0};
      end
   end

   // divider and output register
   logic              dv_valid;
   logic [QUO_W-1:0]  dv_qx, dv_qy;
   logic [SIDE_W-1:0] dv_side;

   segi_div #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (ce),
      .in_valid  (v9_ff),
      .in_num_x  (remx_9_ff),
      .in_num_y  (remy_9_ff),
      .in_div    (div_9_ff),
      .in_side   (side_9_ff),
      .out_valid (dv_valid),
      .out_quo_x (dv_qx),
      .out_quo_y (dv_qy),
      .out_side  (dv_side)
   );

   logic                 f_hit, f_negx, f_negy;
   logic signed [W-1:0]  f_x1, f_y1;
   logic signed [W+1:0]  offx, offy, sumx, sumy;
   logic signed [W-1:0]  cross_x_in, cross_y_in;
   logic                 hit_ff;
   logic signed [W-1:0]  cross_x_ff, cross_y_ff;

   always_comb begin
      {f_hit, f_negx, f_negy, f_x1, f_y1} = dv_side;
      offx = f_negx ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
      offy = f_negy ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
      sumx = (W+2)'(f_x1) + offx;
      sumy = (W+2)'(f_y1) + offy;
      cross_x_in = f_hit ? sumx[W-1:0] : '0;
      cross_y_in = f_hit ? sumy[W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (ce) begin
         out_v_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         hit_ff     <= f_hit;
         cross_x_ff <= cross_x_in;
         cross_y_ff <= cross_y_in;
      end
   end

   assign rsp_chan.valid   = out_v_ff;
   assign rsp_chan.hit     = hit_ff;
   assign rsp_chan.cross_x = cross_x_ff;
   assign rsp_chan.cross_y = cross_y_ff;

endmodule

/* hdl/segi_div.sv */
// pipelined restoring divider, one quotient bit per stage, two lanes on one divisor
// depends on segi_pkg; instantiated by segment_intersection_core

module segi_div
   import segi_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   localparam int REM_W  = 3 * COORD_WIDTH + 3,
   localparam int DIV_W  = 2 * COORD_WIDTH + 3,
   localparam int QUO_W  = COORD_WIDTH + 1,
   localparam int SIDE_W = 2 * COORD_WIDTH + 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [REM_W-1:0]  in_num_x,
   input  logic [REM_W-1:0]  in_num_y,
   input  logic [DIV_W-1:0]  in_div,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo_x,
   output logic [QUO_W-1:0]  out_quo_y,
   output logic [SIDE_W-1:0] out_side
);

   localparam int NS = QUO_W;

   logic              v_ff    [1:NS];
   logic [REM_W-1:0]  rx_ff   [1:NS];
   logic [REM_W-1:0]  ry_ff   [1:NS];
   logic [DIV_W-1:0]  d_ff    [1:NS];
   logic [QUO_W-1:0]  qx_ff   [1:NS];
   logic [QUO_W-1:0]  qy_ff   [1:NS];
   logic [SIDE_W-1:0] side_ff [1:NS];

   for (genvar i = 0; i < NS; i++) begin : g_stage
      localparam int K = NS - 1 - i;

      logic              cur_v;
      logic [REM_W-1:0]  cur_rx;
      logic [REM_W-1:0]  cur_ry;
      logic [DIV_W-1:0]  cur_d;
      logic [QUO_W-1:0]  cur_qx;
      logic [QUO_W-1:0]  cur_qy;
      logic [SIDE_W-1:0] cur_side;
      logic [REM_W-1:0]  sh_d;
      logic [REM_W:0]    diff_x;
      logic [REM_W:0]    diff_y;
      logic [REM_W-1:0]  rx_in;
      logic [REM_W-1:0]  ry_in;
      logic [QUO_W-1:0]  qx_in;
      logic [QUO_W-1:0]  qy_in;

      if (i == 0) begin : g_first
         assign cur_v    = in_valid;
         assign cur_rx   = in_num_x;
         assign cur_ry   = in_num_y;
         assign cur_d    = in_div;
         assign cur_qx   = '0;
         assign cur_qy   = '0;
         assign cur_side = in_side;
      end else begin : g_next
         assign cur_v    = v_ff[i];
         assign cur_rx   = rx_ff[i];
         assign cur_ry   = ry_ff[i];
         assign cur_d    = d_ff[i];
         assign cur_qx   = qx_ff[i];
         assign cur_qy   = qy_ff[i];
         assign cur_side = side_ff[i];
      end

      always_comb begin
         sh_d   = REM_W'(cur_d) << K;
         diff_x = {1'b0, cur_rx} - {1'b0, sh_d};
         diff_y = {1'b0, cur_ry} - {1'b0, sh_d};
         rx_in  = diff_x[REM_W] ? cur_rx : diff_x[REM_W-1:0];
         ry_in  = diff_y[REM_W] ? cur_ry : diff_y[REM_W-1:0];
         qx_in  = cur_qx;
         qy_in  = cur_qy;
         qx_in[K] = ~diff_x[REM_W];
         qy_in[K] = ~diff_y[REM_W];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (enable) begin
            v_ff[i+1] <= cur_v;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rx_ff[i+1]   <= rx_in;
            ry_ff[i+1]   <= ry_in;
            d_ff[i+1]    <= cur_d;
            qx_ff[i+1]   <= qx_in;
            qy_ff[i+1]   <= qy_in;
            side_ff[i+1] <= cur_side;
         end
      end
   end

   assign out_valid = v_ff[NS];
   assign out_quo_x = qx_ff[NS];
   assign out_quo_y = qy_ff[NS];
   assign out_side  = side_ff[NS];

endmodule
